// ===== rtl/core/qlbs_pkg.sv =====
// Shared types and constants for the queued LED blink sequencer.
// No dependencies; qlbs_front, qlbs_cmd_queue, qlbs_back and the top level use it.
package qlbs_pkg;

   // Default request FIFO depth
   localparam int QUEUE_DEPTH_DEFAULT = 8;

   // Field widths
   localparam int TICK_W  = 16;
   localparam int QCOUNT_W = 4;

   // Item kinds on the request channel
   localparam logic ACTION_ENQUEUE = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;

   // One blink request as held in the FIFO
   typedef struct packed {
      logic [TICK_W-1:0] blink_count;
      logic [TICK_W-1:0] on_ticks;
      logic [TICK_W-1:0] off_ticks;
   } blink_req_type;

   // Classified item passed from front to back
   typedef struct packed {
      logic          is_tick;
      blink_req_type req;
   } cmd_type;

   // One result item
   typedef struct packed {
      logic                led_lit;
      logic                sequencer_busy;
      logic [QCOUNT_W-1:0] queue_count;
      logic                request_dropped;
   } rsp_type;

endpackage

// ===== rtl/core/qlbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qlbs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/qlbs_front.sv =====
// Front stage: accepts request items, classifies them and registers them.
// Depends on qlbs_pkg.
module qlbs_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [qlbs_pkg::TICK_W-1:0]     req_blink_count,
   input  logic [qlbs_pkg::TICK_W-1:0]     req_on_ticks,
   input  logic [qlbs_pkg::TICK_W-1:0]     req_off_ticks,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output qlbs_pkg::cmd_type               cmd
);

   logic              valid_ff;
   logic              valid_in;
   qlbs_pkg::cmd_type cmd_ff;
   qlbs_pkg::cmd_type cmd_in;
   logic              push;
   logic              accept;

   // Stage moves on when the queue takes it
   assign push      = valid_ff && cmd_ready;
   assign req_stall = valid_ff && !cmd_ready;
   assign accept    = req_valid && !req_stall;

   // Classify the incoming transfer
   always_comb begin
      cmd_in                 = cmd_ff;
      valid_in               = push ? 1'b0 : valid_ff;
      if (accept) begin
         cmd_in.is_tick         = (req_action == qlbs_pkg::ACTION_TICK);
         cmd_in.req.blink_count = req_blink_count;
         cmd_in.req.on_ticks    = req_on_ticks;
         cmd_in.req.off_ticks   = req_off_ticks;
         valid_in               = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ===== rtl/core/qlbs_cmd_queue.sv =====
// Two-entry queue of classified items between front and back.
// Depends on qlbs_pkg.
module qlbs_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qlbs_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_take,
   output qlbs_pkg::cmd_type out_cmd
);

   qlbs_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_take;
   assign out_cmd   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/core/qlbs_back.sv =====
// Back stage: request FIFO control, blink engine and result register.
// Depends on qlbs_pkg and qlbs_ram.
module qlbs_back #(
   parameter int QUEUE_DEPTH = qlbs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  qlbs_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qlbs_pkg::rsp_type rsp
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_X = (CNT_W > qlbs_pkg::QCOUNT_W) ? CNT_W : qlbs_pkg::QCOUNT_W;
   localparam int TW    = qlbs_pkg::TICK_W;

   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic [TW-1:0]           rep_ff, rep_in;
   logic [TW-1:0]           lit_ff, lit_in;
   logic [TW-1:0]           dark_ff, dark_in;
   logic                    led_ff, led_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   qlbs_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [$bits(qlbs_pkg::blink_req_type)-1:0] ram_rd_data;
   qlbs_pkg::blink_req_type act;
   logic [CNT_X-1:0]        count_x;
   logic                    full;
   logic                    dropped;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Request store; read data stays as the active request after a pop
   qlbs_ram #(
      .WIDTH ($bits(qlbs_pkg::blink_req_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd.req),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign act      = qlbs_pkg::blink_req_type'(ram_rd_data);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign cmd_take = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   // Execute one item per transfer
   always_comb begin
      logic [TW-1:0] lit_after;
      logic [TW-1:0] dark_after;
      logic          dark_step;

      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      rep_in    = rep_ff;
      lit_in    = lit_ff;
      dark_in   = dark_ff;
      led_in    = led_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      dropped   = 1'b0;

      // Lit phase, then dark phase, then repeat bookkeeping
      lit_after  = (lit_ff < act.on_ticks) ? lit_ff + 1'b1 : lit_ff;
      dark_step  = (lit_after >= act.on_ticks) && (dark_ff < act.off_ticks);
      dark_after = dark_step ? dark_ff + 1'b1 : dark_ff;

      if (cmd_take) begin
         if (!cmd.is_tick) begin
            if (full) begin
               dropped = 1'b1;
            end else begin
               ram_wr_en = 1'b1;
               wr_ptr_in = next_slot(wr_ptr_ff);
               count_in  = count_ff + 1'b1;
            end
         end else if (!busy_ff) begin
            if (count_ff != '0) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = next_slot(rd_ptr_ff);
               count_in  = count_ff - 1'b1;
               busy_in   = 1'b1;
               rep_in    = '0;
               lit_in    = '0;
               dark_in   = '0;
            end
         end else if (rep_ff < act.blink_count) begin
            if (lit_ff < act.on_ticks) begin
               led_in = 1'b1;
            end
            if (dark_step) begin
               led_in = 1'b0;
            end
            if ((dark_after >= act.off_ticks) && (lit_after >= act.on_ticks)) begin
               rep_in  = rep_ff + 1'b1;
               lit_in  = '0;
               dark_in = '0;
            end else begin
               lit_in  = lit_after;
               dark_in = dark_after;
            end
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   // Result register: loads on a transfer, holds while stalled
   assign count_x      = CNT_X'(count_in);
   assign rsp_valid_in = cmd_take || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd_take) begin
         rsp_in.led_lit         = led_in;
         rsp_in.sequencer_busy  = busy_in;
         rsp_in.queue_count     = count_x[qlbs_pkg::QCOUNT_W-1:0];
         rsp_in.request_dropped = dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rep_ff       <= '0;
         lit_ff       <= '0;
         dark_ff      <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rep_ff       <= rep_in;
         lit_ff       <= lit_in;
         dark_ff      <= dark_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/queued_led_blink_sequencer.sv =====
// Queued LED blink sequencer: top level.
// Depends on qlbs_pkg, qlbs_front, qlbs_cmd_queue, qlbs_back and qlbs_ram.
//
// Usage:
//   The req_ channel carries one item per transfer: req_action selects an
//   enqueue of a blink request (blink_count, on_ticks, off_ticks) or one
//   timing tick. Every item yields exactly one result on the rsp_ channel:
//   LED level, busy flag, requests waiting and a drop flag for an enqueue
//   refused because the request FIFO was full.
//   A transfer happens on a rising edge with valid high and stall low.
//   Path: a transferred item passes the front register, then the item queue,
//   then the result register in the back stage.
//   Throughput: one item per cycle while rsp_stall is low; every item is a single
//   back-stage pass with at most one request-store access and a few 16-bit compares.
//   When rsp_stall is high the result register holds; the two-entry item
//   queue and the front register absorb items, then req_stall rises.
//   Reset (synchronous, active high) empties the FIFO and item queue, clears
//   the counters and darkens the LED. The request store itself is not
//   cleared; only written entries are ever read.
module queued_led_blink_sequencer #(
   parameter int QUEUE_DEPTH = qlbs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [qlbs_pkg::TICK_W-1:0]       req_blink_count,
   input  logic [qlbs_pkg::TICK_W-1:0]       req_on_ticks,
   input  logic [qlbs_pkg::TICK_W-1:0]       req_off_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_led_lit,
   output logic                              rsp_sequencer_busy,
   output logic [qlbs_pkg::QCOUNT_W-1:0]     rsp_queue_count,
   output logic                              rsp_request_dropped
);

   logic              front_valid;
   logic              front_ready;
   qlbs_pkg::cmd_type front_cmd;
   logic              queue_valid;
   logic              queue_take;
   qlbs_pkg::cmd_type queue_cmd;
   qlbs_pkg::rsp_type rsp;

   qlbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_blink_count (req_blink_count),
      .req_on_ticks    (req_on_ticks),
      .req_off_ticks   (req_off_ticks),
      .cmd_valid       (front_valid),
      .cmd_ready       (front_ready),
      .cmd             (front_cmd)
   );

   qlbs_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_take  (queue_take),
      .out_cmd   (queue_cmd)
   );

   qlbs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_take  (queue_take),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_led_lit         = rsp.led_lit;
   assign rsp_sequencer_busy  = rsp.sequencer_busy;
   assign rsp_queue_count     = rsp.queue_count;
   assign rsp_request_dropped = rsp.request_dropped;

endmodule
